// File: rtl/chpe_pkg.sv
// Shared types for the complex Horner polynomial evaluator.
// No dependencies; imported by the front, back and top-level modules.
package chpe_pkg;

  // Head-of-queue status handed from the front to the back.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } chpe_ctrl_t;

  localparam int unsigned QueueDepth = 2;

endpackage

// File: rtl/chpe_front.sv
// Front end: accepts coefficient transactions and queues them with their marks.
// Depends on chpe_pkg for the head status struct and the queue depth.
module chpe_front import chpe_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] coef_re_i,
  input  logic signed [DATA_WIDTH-1:0] coef_im_i,
  input  logic signed [DATA_WIDTH-1:0] point_re_i,
  input  logic signed [DATA_WIDTH-1:0] point_im_i,
  input  logic                         first_coef_i,
  input  logic                         last_coef_i,
  input  logic                         pop_i,
  output chpe_ctrl_t                   head_o,
  output logic signed [DATA_WIDTH-1:0] head_coef_re_o,
  output logic signed [DATA_WIDTH-1:0] head_coef_im_o,
  output logic signed [DATA_WIDTH-1:0] head_point_re_o,
  output logic signed [DATA_WIDTH-1:0] head_point_im_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] coef_re;
    logic [DATA_WIDTH-1:0] coef_im;
    logic [DATA_WIDTH-1:0] point_re;
    logic [DATA_WIDTH-1:0] point_im;
    logic                  first;
    logic                  last;
  } entry_t;

  entry_t          slot_q [QueueDepth];
  entry_t          head;
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;

  assign in_stall_o = (cnt_q == CntW'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{coef_re: coef_re_i, coef_im: coef_im_i,
                            point_re: point_re_i, point_im: point_im_i,
                            first: first_coef_i, last: last_coef_i};
    end
  end

  assign head            = slot_q[rd_ptr_q];
  assign head_o.valid    = (cnt_q != '0);
  assign head_o.first    = head.first;
  assign head_o.last     = head.last;
  assign head_coef_re_o  = head.coef_re;
  assign head_coef_im_o  = head.coef_im;
  assign head_point_re_o = head.point_re;
  assign head_point_im_o = head.point_im;

endmodule

// File: rtl/chpe_back.sv
// Back end: Horner step acc = acc*z + coef with rounded products and saturation,
// plus the result register. Depends on chpe_pkg for the head status struct.
module chpe_back import chpe_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chpe_ctrl_t                   head_i,
  input  logic signed [DATA_WIDTH-1:0] head_coef_re_i,
  input  logic signed [DATA_WIDTH-1:0] head_coef_im_i,
  input  logic signed [DATA_WIDTH-1:0] head_point_re_i,
  input  logic signed [DATA_WIDTH-1:0] head_point_im_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] value_re_o,
  output logic signed [DATA_WIDTH-1:0] value_im_o,
  output logic                         overflow_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * DATA_WIDTH + 2;
  localparam logic signed [PW-1:0] Half = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [W-1:0]  MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  MinVal = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0]   acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [W-1:0]   pt_re_q, pt_re_d, pt_im_q, pt_im_d;
  logic                  sat_q, sat_d;
  logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [PW-1:0]  r_rr, r_ii, r_ri, r_ir;
  logic signed [PW-1:0]  sum_re, sum_im;
  logic                  ovf_re, ovf_im;
  logic signed [W-1:0]   new_re, new_im;
  logic                  out_valid_q, out_valid_d;
  logic signed [W-1:0]   val_re_q, val_im_q;
  logic                  ovf_q;
  logic                  out_free;

  // Four partial products in parallel, each rounded half-up before the sum.
  assign p_rr = acc_re_q * pt_re_q;
  assign p_ii = acc_im_q * pt_im_q;
  assign p_ri = acc_re_q * pt_im_q;
  assign p_ir = acc_im_q * pt_re_q;

  assign r_rr = (PW'(p_rr) + Half) >>> FRAC_BITS;
  assign r_ii = (PW'(p_ii) + Half) >>> FRAC_BITS;
  assign r_ri = (PW'(p_ri) + Half) >>> FRAC_BITS;
  assign r_ir = (PW'(p_ir) + Half) >>> FRAC_BITS;

  assign sum_re = r_rr - r_ii + PW'(head_coef_re_i);
  assign sum_im = r_ri + r_ir + PW'(head_coef_im_i);

  // In range when every bit from the sign down to bit W-1 agrees.
  assign ovf_re = !((&sum_re[PW-1:W-1]) || !(|sum_re[PW-1:W-1]));
  assign ovf_im = !((&sum_im[PW-1:W-1]) || !(|sum_im[PW-1:W-1]));

  assign new_re = ovf_re ? (sum_re[PW-1] ? MinVal : MaxVal) : sum_re[W-1:0];
  assign new_im = ovf_im ? (sum_im[PW-1] ? MinVal : MaxVal) : sum_im[W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = head_i.valid && (!head_i.last || out_free);

  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    pt_re_d  = pt_re_q;
    pt_im_d  = pt_im_q;
    sat_d    = sat_q;
    if (pop_o) begin
      if (head_i.first) begin
        acc_re_d = head_coef_re_i;
        acc_im_d = head_coef_im_i;
        pt_re_d  = head_point_re_i;
        pt_im_d  = head_point_im_i;
        sat_d    = 1'b0;
      end else begin
        acc_re_d = new_re;
        acc_im_d = new_im;
        sat_d    = sat_q || ovf_re || ovf_im;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && head_i.last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      pt_re_q     <= '0;
      pt_im_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_re_q    <= acc_re_d;
      acc_im_q    <= acc_im_d;
      pt_re_q     <= pt_re_d;
      pt_im_q     <= pt_im_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      val_re_q <= acc_re_d;
      val_im_q <= acc_im_d;
      ovf_q    <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_re_o  = val_re_q;
  assign value_im_o  = val_im_q;
  assign overflow_o  = ovf_q;

endmodule

// File: rtl/complex_horner_poly_eval.sv
// Complex Horner evaluator, signed fixed point. A last-marked transaction is queued,
// popped into the back end, and its value is shown from the result register.
// Throughput: one coefficient per cycle unless out_stall_i holds a last one; set by
// the complex multiply-add loop (four parallel multipliers) around the accumulator.
// Reset (async, active low) clears the queue, result valid, accumulator, point, flag.
module complex_horner_poly_eval import chpe_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] coef_re_i,
  input  logic signed [DATA_WIDTH-1:0] coef_im_i,
  input  logic signed [DATA_WIDTH-1:0] point_re_i,
  input  logic signed [DATA_WIDTH-1:0] point_im_i,
  input  logic                         first_coef_i,
  input  logic                         last_coef_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] value_re_o,
  output logic signed [DATA_WIDTH-1:0] value_im_o,
  output logic                         overflow_o
);

  chpe_ctrl_t                   head;
  logic signed [DATA_WIDTH-1:0] h_coef_re, h_coef_im, h_point_re, h_point_im;
  logic                         pop;

  chpe_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .coef_re_i      (coef_re_i),
    .coef_im_i      (coef_im_i),
    .point_re_i     (point_re_i),
    .point_im_i     (point_im_i),
    .first_coef_i   (first_coef_i),
    .last_coef_i    (last_coef_i),
    .pop_i          (pop),
    .head_o         (head),
    .head_coef_re_o (h_coef_re),
    .head_coef_im_o (h_coef_im),
    .head_point_re_o(h_point_re),
    .head_point_im_o(h_point_im)
  );

  chpe_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_coef_re_i (h_coef_re),
    .head_coef_im_i (h_coef_im),
    .head_point_re_i(h_point_re),
    .head_point_im_i(h_point_im),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_re_o     (value_re_o),
    .value_im_o     (value_im_o),
    .overflow_o     (overflow_o)
  );

endmodule

// File: rtl/chpe_checker.sv
// Port-level checker for complex_horner_poly_eval, attached by the bind below.
// Depends only on the top-level ports.
module chpe_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  last_coef_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DATA_WIDTH-1:0] value_re_o,
  input logic [DATA_WIDTH-1:0] value_im_o,
  input logic                  overflow_o
);

  // Results owed: last-marked transactions in minus results out.
  logic [2:0] owed_q;
  logic       in_last, out_acc;

  assign in_last = in_valid_i && !in_stall_o && last_coef_i;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else if (in_last && !out_acc) begin
      owed_q <= owed_q + 3'd1;
    end else if (!in_last && out_acc) begin
      owed_q <= owed_q - 3'd1;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (owed_q != 3'd0))
    else $error("result shown with no last transaction outstanding");

  a_owed_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q <= 3'd3)
    else $error("more results outstanding than queue and output can hold");

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(value_re_o) && $stable(value_im_o) && $stable(overflow_o))
    else $error("output payload changed while stalled");

endmodule

bind complex_horner_poly_eval chpe_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_chpe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .last_coef_i(last_coef_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .value_re_o (value_re_o),
  .value_im_o (value_im_o),
  .overflow_o (overflow_o)
);

// File: tb/tb_complex_horner_poly_eval.sv
// Self-checking testbench for complex_horner_poly_eval (Horner's rule, Q8.24).
// Depends only on the RTL top level; a scoreboard class predicts each value.
`timescale 1ns / 1ps

module tb_complex_horner_poly_eval;

  localparam int DW = 32;
  localparam int FB = 24;
  localparam int ITEMS = 1850;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [2*DW+3:0] wide_t;

  localparam word_t WORD_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam word_t Q_ONE = word_t'(1) <<< FB;
  localparam word_t Q_HALF = word_t'(1) <<< (FB - 1);

  typedef struct {
    word_t re;
    word_t im;
    word_t pre;
    word_t pim;
    bit    first;
    bit    last;
  } coef_item_t;

  typedef struct {
    word_t re;
    word_t im;
    bit    ovf;
  } poly_value_t;

  class horner_scoreboard;
    word_t acc_re, acc_im, pt_re, pt_im;
    bit sat_seen;
    poly_value_t pending_values[$];
    int mismatches, values_checked, ovf_values;

    function new();
      acc_re = '0;
      acc_im = '0;
      pt_re = '0;
      pt_im = '0;
      sat_seen = 1'b0;
    endfunction

    // Exact product, rounded to nearest with ties upward.
    function wide_t round_product(word_t a, word_t b);
      wide_t wa, wb;
      wa = a;
      wb = b;
      return (wa * wb + (wide_t'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function word_t clamp(wide_t s);
      if (s > wide_t'(WORD_MAX)) begin
        sat_seen = 1'b1;
        return WORD_MAX;
      end
      if (s < wide_t'(WORD_MIN)) begin
        sat_seen = 1'b1;
        return WORD_MIN;
      end
      return word_t'(s);
    endfunction

    function void note_coef(coef_item_t c);
      wide_t sum_re, sum_im;
      if (c.first) begin
        acc_re = c.re;
        acc_im = c.im;
        pt_re = c.pre;
        pt_im = c.pim;
        sat_seen = 1'b0;
      end else begin
        sum_re = round_product(acc_re, pt_re) - round_product(acc_im, pt_im) + wide_t'(c.re);
        sum_im = round_product(acc_re, pt_im) + round_product(acc_im, pt_re) + wide_t'(c.im);
        acc_re = clamp(sum_re);
        acc_im = clamp(sum_im);
      end
      if (c.last) pending_values.push_back('{acc_re, acc_im, sat_seen});
    endfunction

    function void check_value(word_t re, word_t im, logic ovf);
      poly_value_t exp_val;
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected value re=%h im=%h ovf=%b", re, im, ovf);
        return;
      end
      exp_val = pending_values.pop_front();
      values_checked++;
      if (exp_val.ovf) ovf_values++;
      if (exp_val.re !== re || exp_val.im !== im || exp_val.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: value %0d exp re=%h im=%h ovf=%b got re=%h im=%h ovf=%b",
                   values_checked, exp_val.re, exp_val.im, exp_val.ovf, re, im, ovf);
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  word_t coef_re_i = '0;
  word_t coef_im_i = '0;
  word_t point_re_i = '0;
  word_t point_im_i = '0;
  logic  first_coef_i = 1'b0;
  logic  last_coef_i = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  word_t value_re_o;
  word_t value_im_o;
  logic  overflow_o;

  horner_scoreboard sb = new();
  int coefs_sent = 0;
  int polys_started = 0;
  int send_burst = 0;
  int cycle_count = 0;

  complex_horner_poly_eval dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coef_re_i    (coef_re_i),
    .coef_im_i    (coef_im_i),
    .point_re_i   (point_re_i),
    .point_im_i   (point_im_i),
    .first_coef_i (first_coef_i),
    .last_coef_i  (last_coef_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_re_o   (value_re_o),
    .value_im_o   (value_im_o),
    .overflow_o   (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly random waits, with occasional runs of back-to-back cycles.
  function automatic int next_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic word_t rand_word(int shift);
    word_t w;
    w = $urandom;
    return w >>> shift;
  endfunction

  function automatic coef_item_t make_coef(word_t re, word_t im, word_t pre, word_t pim,
                                           bit first, bit last);
    coef_item_t c;
    c.re = re;
    c.im = im;
    c.pre = pre;
    c.pim = pim;
    c.first = first;
    c.last = last;
    return c;
  endfunction

  task automatic send_coef(input coef_item_t c);
    int gap;
    gap = next_wait(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    coef_re_i    <= c.re;
    coef_im_i    <= c.im;
    point_re_i   <= c.pre;
    point_im_i   <= c.pim;
    first_coef_i <= c.first;
    last_coef_i  <= c.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_coef(c);
    coefs_sent++;
    if (c.first) polys_started++;
  endtask

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int wait_cycles;
    int recv_burst;
    bit held;
    recv_burst = 0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      wait_cycles = next_wait(recv_burst);
      if (!held && sb.values_checked >= 120) begin
        held = 1'b1;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_value(value_re_o, value_im_o, overflow_o);
    end
  end

  initial begin
    coef_item_t c;
    int mode, degree, cshift, pshift;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Coefficient before any first: accumulator and point still at reset.
    send_coef(make_coef(WORD_MAX, WORD_MIN, rand_word(0), rand_word(0), 1'b0, 1'b1));
    // Degree-zero polynomials at the extremes.
    send_coef(make_coef(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 1'b1, 1'b1));
    send_coef(make_coef('0, '0, '0, '0, 1'b1, 1'b1));
    send_coef(make_coef(-word_t'(1), word_t'(1), WORD_MIN, WORD_MAX, 1'b1, 1'b1));
    // Rounding ties: one LSB times one half, both signs.
    send_coef(make_coef(word_t'(1), -word_t'(1), Q_HALF, '0, 1'b1, 1'b0));
    send_coef(make_coef('0, '0, rand_word(0), rand_word(0), 1'b0, 1'b1));
    send_coef(make_coef(word_t'(1), -word_t'(1), -Q_HALF, -Q_HALF, 1'b1, 1'b0));
    send_coef(make_coef('0, '0, rand_word(0), rand_word(0), 1'b0, 1'b1));
    // Positive saturation mid-polynomial; flag must stick to the end.
    send_coef(make_coef(WORD_MAX, WORD_MAX, WORD_MAX, '0, 1'b1, 1'b0));
    send_coef(make_coef(WORD_MAX, '0, rand_word(0), rand_word(0), 1'b0, 1'b0));
    send_coef(make_coef('0, '0, rand_word(0), rand_word(0), 1'b0, 1'b1));
    // Most negative point and accumulator.
    send_coef(make_coef(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1, 1'b0));
    send_coef(make_coef(WORD_MIN, WORD_MIN, rand_word(0), rand_word(0), 1'b0, 1'b1));
    // Negative saturation.
    send_coef(make_coef(WORD_MIN, '0, WORD_MAX, '0, 1'b1, 1'b0));
    send_coef(make_coef(WORD_MIN, '0, rand_word(0), rand_word(0), 1'b0, 1'b1));
    // Keep going after a last with no new first: old value, point and flag.
    send_coef(make_coef(Q_ONE, '0, rand_word(0), rand_word(0), 1'b0, 1'b1));
    // Ordinary cubic; new first clears the flag.
    send_coef(make_coef(Q_ONE, -Q_ONE, Q_HALF, Q_HALF >>> 1, 1'b1, 1'b0));
    send_coef(make_coef(Q_HALF, Q_ONE, rand_word(0), rand_word(0), 1'b0, 1'b0));
    send_coef(make_coef(-Q_ONE, Q_HALF, rand_word(0), rand_word(0), 1'b0, 1'b0));
    send_coef(make_coef(Q_ONE <<< 2, -Q_HALF, rand_word(0), rand_word(0), 1'b0, 1'b1));
    // First arriving while a polynomial is still open.
    send_coef(make_coef(Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 1'b1, 1'b0));
    send_coef(make_coef(Q_HALF, -Q_HALF, Q_ONE, Q_HALF, 1'b1, 1'b0));
    send_coef(make_coef(Q_ONE, '0, rand_word(0), rand_word(0), 1'b0, 1'b1));

    while (coefs_sent < ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        // Well-formed polynomial; scale picks how often saturation happens.
        mode = $urandom_range(0, 2);
        cshift = (mode == 0) ? 6 : (mode == 1) ? 0 : 2;
        pshift = (mode == 0) ? 7 : (mode == 1) ? 0 : 6;
        degree = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
        for (int k = 0; k <= degree; k++) begin
          c = make_coef(rand_word(cshift), rand_word(cshift), rand_word(pshift),
                        rand_word(pshift), k == 0, k == degree);
          send_coef(c);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          cshift = $urandom_range(0, 7);
          c = make_coef(rand_word(cshift), rand_word(cshift), rand_word(cshift),
                        rand_word(cshift), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
          send_coef(c);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d coefficients (%0d polynomial starts) in %0d cycles.",
             coefs_sent, polys_started, cycle_count);
    $display("Checked %0d values, %0d with overflow set; %0d mismatches.",
             sb.values_checked, sb.ovf_values, sb.mismatches);
    if (sb.pending_values.size() != 0)
      $display("ERROR: %0d expected values never arrived", sb.pending_values.size());
    if (sb.mismatches == 0 && sb.pending_values.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/chpe_pkg.sv
rtl/chpe_front.sv
rtl/chpe_back.sv
rtl/complex_horner_poly_eval.sv
rtl/chpe_checker.sv
tb/tb_complex_horner_poly_eval.sv
